// File: hdl/wpm_pkg.sv
// Shared types and constants for the wheel speed pulse period meter.
// Used by wpm_div and wheel_speed_pulse_period_meter_top; no dependencies.
package wpm_pkg;

    localparam int TS_W       = 32;
    localparam int SPEED_W    = 24;
    localparam int WC_W       = 24;
    localparam int BPR_W      = 4;
    localparam int ZD_W       = 16;
    localparam int MAX_W      = 24;
    localparam int DVS_W      = TS_W + BPR_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_CONSTANT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOLTS_PER_REV  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_DELAY_MS  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED_Q8   = 8'd3;

    localparam logic [WC_W-1:0]    WHEEL_CONSTANT_RST = 24'd1544351;
    localparam logic [BPR_W-1:0]   BOLTS_PER_REV_RST  = 4'd4;
    localparam logic [ZD_W-1:0]    ZERO_DELAY_RST     = 16'd10000;
    localparam logic [MAX_W-1:0]   MAX_SPEED_RST      = 24'd12800;
    localparam logic [SPEED_W-1:0] LAST_GOOD_RST      = 24'd256;

    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_RUN  = 2'd1;
    localparam logic [1:0] EDGE_FULL  = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// File: hdl/wpm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wpm_pkg for default widths and the status struct.
module wpm_div #(
    parameter int DVD_W = wpm_pkg::SPEED_W,
    parameter int DVS_W = wpm_pkg::DVS_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DVD_W-1:0]     i_dividend,
    input  logic [DVS_W-1:0]     i_divisor,
    output logic [DVD_W-1:0]     o_quotient,
    output wpm_pkg::t_div_status o_status
);
    import wpm_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   w_trial;
    logic             w_fits;

    // A zero divisor always fits, so the quotient comes out all ones (saturated).
    always_comb begin
        w_trial = {r_rem, r_quo[DVD_W-1]};
        w_fits  = w_trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
                r_cnt  <= CNT_W'(DVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_fits ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], w_fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient    = r_quo;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

// File: hdl/wheel_speed_pulse_period_meter_top.sv
// Wheel speed meter from hall pulse periods: sequencer, state and output register.
// Depends on wpm_pkg and wpm_div.
//
//  channel  | direction | handshake                | beat contents
//  ---------+-----------+--------------------------+-------------------------------------
//  in       | in        | i_in_valid / o_in_stall  | i_kind, i_timestamp_ms
//  out      | out       | o_out_valid / i_out_stall| o_speed_q8, o_accepted, o_rejected,
//           |           |                          | o_timed_out
//  cfg      | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// End edge: evaluate, divider load, divider steps (one per quotient bit), divider done,
// decide, output. Start edges and timeout checks: evaluate, output. o_in_stall is high
// until the result is registered, so no new item is taken while one is in progress.
// A full output register stalls the sequencer in its last state only.
// Reset (synchronous, active low) loads register defaults and clears the history.
module wheel_speed_pulse_period_meter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic [wpm_pkg::TS_W-1:0]          i_timestamp_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [wpm_pkg::SPEED_W-1:0]       o_speed_q8,
    output logic                              o_accepted,
    output logic                              o_rejected,
    output logic                              o_timed_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wpm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wpm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import wpm_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DWAIT  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]         r_state;
    logic [2:0]         n_state;

    logic [WC_W-1:0]    r_wheel_constant;
    logic [BPR_W-1:0]   r_bolts_per_rev;
    logic [ZD_W-1:0]    r_zero_delay;
    logic [MAX_W-1:0]   r_max_speed;

    logic [1:0]         r_phase;
    logic [TS_W-1:0]    r_start_time;
    logic [1:0]         r_edge_count;
    logic [SPEED_W-1:0] r_speed;
    logic [SPEED_W-1:0] r_last_good;

    logic               r_kind;
    logic [TS_W-1:0]    r_ts;
    logic [DVS_W-1:0]   r_divisor;
    logic               r_acc;
    logic               r_rej;
    logic               r_tmo;

    logic               r_out_valid;
    logic [SPEED_W-1:0] r_out_speed;
    logic               r_out_acc;
    logic               r_out_rej;
    logic               r_out_tmo;

    logic               w_in_fire;
    logic               w_cfg_fire;
    logic               w_out_free;
    logic [TS_W-1:0]    w_interval;
    logic [DVS_W-1:0]   w_product;
    logic               w_bad;
    logic               w_div_start;
    logic [SPEED_W-1:0] w_quotient;
    t_div_status        w_div_stat;

    assign w_in_fire   = i_in_valid && (r_state == S_IDLE);
    assign w_cfg_fire  = i_cfg_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_div_start = (r_state == S_DSTART);

    always_comb begin
        w_interval = r_ts - r_start_time;
        w_product  = {{BPR_W{1'b0}}, w_interval} * {{TS_W{1'b0}}, r_bolts_per_rev};
        // plausibility only once the edge count has reached EDGE_FULL
        w_bad = (w_quotient != '0) && (r_edge_count == EDGE_FULL) &&
                ((w_quotient >= r_max_speed) ||
                 ({1'b0, w_quotient} >= {r_last_good, 1'b0}));
    end

    wpm_div #(
        .DVD_W (SPEED_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_wheel_constant),
        .i_divisor  (r_divisor),
        .o_quotient (w_quotient),
        .o_status   (w_div_stat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = (r_kind == KIND_EDGE && r_phase == PHASE_RUN) ? S_DSTART : S_OUT;
            end
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (w_div_stat.done) n_state = S_DECIDE;
            end
            S_DECIDE: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_wheel_constant <= WHEEL_CONSTANT_RST;
            r_bolts_per_rev  <= BOLTS_PER_REV_RST;
            r_zero_delay     <= ZERO_DELAY_RST;
            r_max_speed      <= MAX_SPEED_RST;
            r_phase          <= PHASE_IDLE;
            r_start_time     <= '0;
            r_edge_count     <= '0;
            r_speed          <= '0;
            r_last_good      <= LAST_GOOD_RST;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_fire) begin
                case (i_cfg_index)
                    CFG_WHEEL_CONSTANT: r_wheel_constant <= i_cfg_data[WC_W-1:0];
                    CFG_BOLTS_PER_REV:  r_bolts_per_rev  <= i_cfg_data[BPR_W-1:0];
                    CFG_ZERO_DELAY_MS:  r_zero_delay     <= i_cfg_data[ZD_W-1:0];
                    CFG_MAX_SPEED_Q8:   r_max_speed      <= i_cfg_data[MAX_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_kind <= i_kind;
                        r_ts   <= i_timestamp_ms;
                        r_acc  <= 1'b0;
                        r_rej  <= 1'b0;
                        r_tmo  <= 1'b0;
                    end
                end
                S_EVAL: begin
                    if (r_kind == KIND_EDGE) begin
                        if (r_edge_count != EDGE_FULL) r_edge_count <= r_edge_count + 1'b1;
                        if (r_phase == PHASE_RUN) begin
                            r_divisor <= w_product;
                        end else begin
                            r_start_time <= r_ts;
                            r_phase      <= PHASE_RUN;
                        end
                    end else if (w_interval >= {{(TS_W-ZD_W){1'b0}}, r_zero_delay}) begin
                        r_speed      <= '0;
                        r_edge_count <= '0;
                        r_tmo        <= 1'b1;
                    end
                end
                S_DECIDE: begin
                    if (w_bad) begin
                        r_phase <= PHASE_IDLE;
                        r_rej   <= 1'b1;
                    end else begin
                        r_speed      <= w_quotient;
                        r_last_good  <= w_quotient;
                        r_start_time <= r_ts;
                        r_acc        <= 1'b1;
                    end
                end
                default: ;
            endcase

            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_speed <= r_speed;
                r_out_acc   <= r_acc;
                r_out_rej   <= r_rej;
                r_out_tmo   <= r_tmo;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_speed_q8  = r_out_speed;
    assign o_accepted  = r_out_acc;
    assign o_rejected  = r_out_rej;
    assign o_timed_out = r_out_tmo;

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_accepted, o_rejected, o_timed_out}))
        else $error("more than one outcome flag in a result beat");

    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_timed_out) |-> (o_speed_q8 == '0))
        else $error("timeout result with nonzero speed");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider started while busy");

    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second beat taken while one is in progress");

endmodule
